// ===== rtl/core/mma_pkg.sv =====
// Shared constants, types and helper functions of the midpoint moving average block.
`default_nettype none

package mma_pkg;

  localparam int HISTORY_DEPTH = 256;
  localparam int MAX_WINDOWS   = 4;
  localparam int PRICE_BITS    = 32;

  // Number of window length registers.
  localparam int LEN_REGS  = 4;
  localparam int WIN_LIMIT = (MAX_WINDOWS < LEN_REGS) ? MAX_WINDOWS : LEN_REGS;

  localparam int RING_AW  = $clog2(HISTORY_DEPTH);
  localparam int RING_W   = PRICE_BITS + 1;
  localparam int BARS_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_BITS = RING_W + RING_AW;
  localparam int K_W      = (WIN_LIMIT > 1) ? $clog2(WIN_LIMIT) : 1;

  localparam int LEN_BITS   = 9;
  localparam int CNT_BITS   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int OUT_IDX_W  = 2;
  localparam int LEN_SEL_W  = (LEN_REGS > 1) ? $clog2(LEN_REGS) : 1;

  // Quotient bits produced per divider step.
  localparam int RADIX_BITS = 4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEN_BASE     = CFG_IDX_W'(1);

  localparam logic [CNT_BITS-1:0] CNT_RESET = CNT_BITS'(1);
  localparam logic [LEN_BITS-1:0] LEN_RESET [LEN_REGS] = '{9'd20, 9'd50, 9'd100, 9'd200};

  typedef struct packed {
    logic [CNT_BITS-1:0]              win_cnt;
    logic [LEN_REGS-1:0][BARS_W-1:0]  win_len;
    logic                             restart;
  } mma_cfg_t;

  // Window length as used: zero counts as one, long windows stop at the ring depth.
  function automatic logic [BARS_W-1:0] eff_len(input logic [LEN_BITS-1:0] raw);
    logic [BARS_W-1:0] res;
    if (raw == '0) begin
      res = BARS_W'(1);
    end else if (32'(raw) > HISTORY_DEPTH) begin
      res = BARS_W'(HISTORY_DEPTH);
    end else begin
      res = BARS_W'(raw);
    end
    return res;
  endfunction

  // Active window count: zero counts as one, large values stop at the window limit.
  function automatic logic [CNT_BITS-1:0] eff_cnt(input logic [CNT_BITS-1:0] raw);
    logic [CNT_BITS-1:0] res;
    if (raw == '0) begin
      res = CNT_BITS'(1);
    end else if (32'(raw) > WIN_LIMIT) begin
      res = CNT_BITS'(WIN_LIMIT);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mma_ifs.sv =====
// Handshake channel interfaces for bars, results and configuration writes.
`default_nettype none

interface mma_in_if import mma_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] high_price;
  logic [PRICE_BITS-1:0] low_price;

  modport source (output valid, output high_price, output low_price, input ready);
  modport sink   (input valid, input high_price, input low_price, output ready);
endinterface

interface mma_out_if import mma_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUT_IDX_W-1:0]  window_index;
  logic [PRICE_BITS-1:0] average;
  logic                  last;

  modport source (output valid, output window_index, output average, output last,
                  input ready);
  modport sink   (input valid, input window_index, input average, input last,
                  output ready);
endinterface

interface mma_cfg_if import mma_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mma_ring_ram.sv =====
// Single-port-write, single-port-read synchronous RAM holding the bar history.
`default_nettype none

module mma_ring_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 33
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mma_div.sv =====
// Radix-16 restoring divider: window sum over twice the bar count, four quotient bits a cycle.
`default_nettype none

module mma_div import mma_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [SUM_BITS-2:0]   dividend,
  input  wire logic [BARS_W-1:0]     divisor,
  output logic                       done,
  output logic      [PRICE_BITS-1:0] quotient
);

  localparam int DVD_W     = SUM_BITS - 1;
  localparam int DIV_STEPS = (DVD_W + RADIX_BITS - 1) / RADIX_BITS;
  localparam int PAD_W     = DIV_STEPS * RADIX_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  logic [PAD_W-1:0]      dvd_r;
  logic [PAD_W-1:0]      quo_r;
  logic [BARS_W-1:0]     rem_r;
  logic [BARS_W-1:0]     dsr_r;
  logic [STEP_W-1:0]     step_r;
  logic                  busy_r;
  logic                  done_r;

  logic [BARS_W:0]       rem_nxt;
  logic [RADIX_BITS-1:0] qbits_nxt;

  // Each step brings down four dividend bits, one at a time, subtracting where the divisor fits.
  always_comb begin
    rem_nxt   = {1'b0, rem_r};
    qbits_nxt = '0;
    for (int i = 0; i < RADIX_BITS; i++) begin
      rem_nxt = {rem_nxt[BARS_W-1:0], dvd_r[PAD_W-1-i]};
      if (rem_nxt >= {1'b0, dsr_r}) begin
        rem_nxt                      = rem_nxt - {1'b0, dsr_r};
        qbits_nxt[RADIX_BITS-1-i]    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      dvd_r  <= PAD_W'(dividend);
      dsr_r  <= divisor;
      rem_r  <= '0;
      quo_r  <= '0;
      step_r <= STEP_W'(DIV_STEPS);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r  <= dvd_r << RADIX_BITS;
      quo_r  <= {quo_r[PAD_W-RADIX_BITS-1:0], qbits_nxt};
      rem_r  <= rem_nxt[BARS_W-1:0];
      step_r <= step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[PRICE_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/mma_cfg_regs.sv =====
// Configuration registers: window count and window lengths, with the warm-up restart strobe.
`default_nettype none

module mma_cfg_regs import mma_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mma_cfg_if.sink   cfg_wr,
  output mma_cfg_t  cfg
);

  logic [CNT_BITS-1:0] cnt_raw_r;
  logic [LEN_BITS-1:0] len_raw_r [LEN_REGS];

  logic                 wr_fire;
  logic                 len_hit;
  logic [LEN_SEL_W-1:0] len_sel;
  logic [CFG_IDX_W-1:0] len_off;

  assign cfg_wr.ready = 1'b1;
  assign wr_fire      = cfg_wr.valid && cfg_wr.ready;
  assign len_off      = cfg_wr.index - REG_LEN_BASE;
  assign len_sel      = len_off[LEN_SEL_W-1:0];
  assign len_hit      = (cfg_wr.index >= REG_LEN_BASE) &&
                        (32'(cfg_wr.index) < 32'(REG_LEN_BASE) + LEN_REGS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_raw_r <= CNT_RESET;
      for (int i = 0; i < LEN_REGS; i++) begin
        len_raw_r[i] <= LEN_RESET[i];
      end
    end else if (wr_fire) begin
      if (cfg_wr.index == REG_WINDOW_COUNT) begin
        cnt_raw_r <= cfg_wr.data[CNT_BITS-1:0];
      end else if (len_hit) begin
        len_raw_r[len_sel] <= cfg_wr.data[LEN_BITS-1:0];
      end
    end
  end

  always_comb begin
    cfg.win_cnt = eff_cnt(cnt_raw_r);
    for (int i = 0; i < LEN_REGS; i++) begin
      cfg.win_len[i] = eff_len(len_raw_r[i]);
    end
    // Any length write restarts the warm-up, taking effect on the same edge.
    cfg.restart = wr_fire && len_hit;
  end

endmodule

`default_nettype wire

// ===== rtl/core/midpoint_moving_average_top.sv =====
// Each accepted bar is taken through every window in turn; active windows give results in
// window order, and no new bar is accepted until the last window is done. The pace is
// set by the sequencer walking every window through one ring read and one shared divider
// that yields four quotient bits a cycle, and a stalled output holds the sequencer.
// Reset (synchronous, rst_n low): registers to their defaults, pointer, bar count and sums
// cleared; the history RAM is not cleared and needs no clearing pass.
`default_nettype none

module midpoint_moving_average_top import mma_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mma_in_if.sink     in_bar,
  mma_out_if.source  out_res,
  mma_cfg_if.sink    cfg_wr
);

  // The sequencer visits every window on each bar, active or not, because the running
  // sums of inactive windows must stay current. Each visit reads the ring entry that
  // leaves the window, updates the sum, and for active windows runs the divider and
  // places the average in the output register. The new bar enters the ring last, so
  // a window as long as the ring reads the entry that is about to be overwritten.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_SUM,
    S_DIV,
    S_NEXT
  } state_t;

  localparam logic [K_W-1:0] K_LAST = K_W'(WIN_LIMIT - 1);

  state_t                state_r;
  logic [K_W-1:0]        k_r;
  logic [RING_W-1:0]     v_r;
  logic [RING_AW-1:0]    wp_r;
  logic [BARS_W-1:0]     bars_r;
  logic [SUM_BITS-1:0]   sum_r [WIN_LIMIT];

  logic                  out_valid_r;
  logic [OUT_IDX_W-1:0]  out_idx_r;
  logic [PRICE_BITS-1:0] out_avg_r;
  logic                  out_last_r;

  mma_cfg_t              cfg;

  logic                  ring_we;
  logic                  ring_re;
  logic [RING_AW-1:0]    ring_raddr;
  logic [RING_W-1:0]     ring_rdata;

  logic                  div_start;
  logic                  div_done;
  logic [PRICE_BITS-1:0] div_quo;
  logic [BARS_W-1:0]     div_den;

  logic [BARS_W-1:0]     len_k;
  logic                  warm;
  logic                  active;
  logic                  is_last;
  logic                  out_free;
  logic                  out_load;
  logic [SUM_BITS-1:0]   sum_nxt;
  logic [RING_W-1:0]     bar_sum;

  mma_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  mma_ring_ram #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (RING_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp_r),
    .wdata (v_r),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  mma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt[SUM_BITS-1:1]),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // The sum of high and low is twice the midpoint, so halving the window sum first
  // leaves a plain division by the bar count.
  always_comb begin
    bar_sum    = RING_W'(in_bar.high_price) + RING_W'(in_bar.low_price);
    len_k      = cfg.win_len[k_r];
    warm       = bars_r < len_k;
    ring_raddr = wp_r - len_k[RING_AW-1:0];
    sum_nxt    = sum_r[k_r] + SUM_BITS'(v_r) - (warm ? '0 : SUM_BITS'(ring_rdata));
    div_den    = warm ? (bars_r + BARS_W'(1)) : len_k;
    active     = CNT_BITS'(k_r) < cfg.win_cnt;
    is_last    = (CNT_BITS'(k_r) + CNT_BITS'(1)) == cfg.win_cnt;
    out_free   = !out_valid_r || out_res.ready;
    out_load   = (state_r == S_DIV) && div_done && out_free;
    ring_re    = (state_r == S_ADDR);
    ring_we    = (state_r == S_NEXT) && (k_r == K_LAST);
    div_start  = (state_r == S_SUM) && active;
  end

  assign in_bar.ready         = (state_r == S_IDLE);
  assign out_res.valid        = out_valid_r;
  assign out_res.window_index = out_idx_r;
  assign out_res.average      = out_avg_r;
  assign out_res.last         = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      wp_r        <= '0;
      bars_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WIN_LIMIT; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      // A new average may replace the beat that leaves on this same edge.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_res.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_bar.valid) begin
            v_r     <= bar_sum;
            k_r     <= '0;
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          state_r <= S_SUM;
        end
        S_SUM: begin
          sum_r[k_r] <= sum_nxt;
          state_r    <= active ? S_DIV : S_NEXT;
        end
        S_DIV: begin
          // The result waits in the divider until the output register is free.
          if (out_load) begin
            out_idx_r   <= OUT_IDX_W'(k_r);
            out_avg_r   <= div_quo;
            out_last_r  <= is_last;
            state_r     <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (k_r == K_LAST) begin
            wp_r <= wp_r + RING_AW'(1);
            if (bars_r != BARS_W'(HISTORY_DEPTH)) begin
              bars_r <= bars_r + BARS_W'(1);
            end
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + K_W'(1);
            state_r <= S_ADDR;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // Length writes restart warm-up; user must write only while block is idle, unenforced.
      if (cfg.restart) begin
        wp_r   <= '0;
        bars_r <= '0;
        for (int i = 0; i < WIN_LIMIT; i++) begin
          sum_r[i] <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the midpoint moving average block, with its scoreboard.
module tb_top import mma_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // A stretch this long without a single beat on any channel means the block has hung.
  localparam int QUIET_LIMIT = 4000;
  // Cycles allowed after the last result of a bar for the block to finish the sums of
  // inactive windows. This covers the longest bar with some margin.
  localparam int SETTLE_CYCLES = 64;

  localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;

  // Idle patterns: none at all, gaps on both sides, gaps on the bar side only,
  // stalls on the result side only.
  typedef enum int {IDLE_NONE, IDLE_BOTH, IDLE_BARS, IDLE_RESULTS} idle_mode_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]  window_index;
    logic [PRICE_BITS-1:0] average;
    logic                  last;
  } avg_result_t;

  // Keeps its own copy of the ring, the running sums and the registers, works out the
  // averages each bar yields and checks the block's results against them in order.
  class avg_scoreboard;
    logic [RING_W-1:0]   bar_sums [HISTORY_DEPTH];
    logic [RING_AW-1:0]  wr_ptr;
    logic [BARS_W-1:0]   seen;
    logic [SUM_BITS-1:0] run_sum [LEN_REGS];
    logic [CNT_BITS-1:0] cnt_reg;
    logic [LEN_BITS-1:0] len_reg [LEN_REGS];
    avg_result_t         expected_avgs [$];
    int                  errors;

    function new();
      errors = 0;
      cnt_reg = CNT_RESET;
      for (int k = 0; k < LEN_REGS; k++) len_reg[k] = LEN_RESET[k];
      restart_warmup();
    endfunction

    function void restart_warmup();
      wr_ptr = '0;
      seen   = '0;
      for (int k = 0; k < LEN_REGS; k++) run_sum[k] = '0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_WINDOW_COUNT) begin
        cnt_reg = data[CNT_BITS-1:0];
      end else if (idx >= REG_LEN_BASE && idx < REG_LEN_BASE + LEN_REGS) begin
        len_reg[LEN_SEL_W'(idx - REG_LEN_BASE)] = data[LEN_BITS-1:0];
        restart_warmup();
      end
    endfunction

    function void note_bar(logic [PRICE_BITS-1:0] high_p, logic [PRICE_BITS-1:0] low_p);
      logic [RING_W-1:0] pair;
      int unsigned       active;
      int unsigned       span;
      int unsigned       divisor;
      logic [63:0]       quot;
      avg_result_t       res;
      pair = RING_W'(high_p) + RING_W'(low_p);
      if (cnt_reg == '0) active = 1;
      else if (cnt_reg > WIN_LIMIT) active = WIN_LIMIT;
      else active = cnt_reg;
      for (int k = 0; k < WIN_LIMIT; k++) begin
        if (len_reg[k] == '0) span = 1;
        else if (len_reg[k] > HISTORY_DEPTH) span = HISTORY_DEPTH;
        else span = len_reg[k];
        if (seen < span) begin
          run_sum[k] = run_sum[k] + pair;
          divisor = seen + 1;
        end else begin
          run_sum[k] = run_sum[k] + pair - bar_sums[RING_AW'(wr_ptr - span)];
          divisor = span;
        end
        if (k < active) begin
          quot = 64'(run_sum[k]) / (64'(divisor) * 2);
          res.window_index = OUT_IDX_W'(k);
          res.average      = quot[PRICE_BITS-1:0];
          res.last         = (k + 1 == active);
          expected_avgs.insert(expected_avgs.size(), res);
        end
      end
      bar_sums[wr_ptr] = pair;
      wr_ptr = wr_ptr + 1'b1;
      if (seen < HISTORY_DEPTH) seen = seen + 1'b1;
    endfunction

    task check_result(logic [OUT_IDX_W-1:0] idx, logic [PRICE_BITS-1:0] avg, logic fin);
      avg_result_t want;
      if (expected_avgs.size() == 0) begin
        report($sformatf("unexpected result window %0d average %0d last %0b", idx, avg, fin));
      end else begin
        want = expected_avgs.pop_front();
        if (idx !== want.window_index || avg !== want.average || fin !== want.last)
          report($sformatf("window %0d/%0d average %0d/%0d last %0b/%0b (got/expected)",
                           idx, want.window_index, avg, want.average, fin, want.last));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  mma_in_if  bar_ch ();
  mma_out_if avg_ch ();
  mma_cfg_if reg_ch ();

  midpoint_moving_average_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bar  (bar_ch),
    .out_res (avg_ch),
    .cfg_wr  (reg_ch)
  );

  avg_scoreboard sb = new();
  idle_mode_t    idle_mode = IDLE_BOTH;
  int            quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap before a beat on the bar or register side. Most gaps are short; now and then a
  // long one lets the block run dry and sit idle between bars.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (idle_mode == IDLE_NONE || idle_mode == IDLE_RESULTS) return 0;
    if (r < 10) return 0;
    if (r < 16) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Length of a stall on the result side; never zero.
  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Mostly random prices, with zero, all ones, near-maximum and small values mixed in so that
  // the high+low sum regularly carries into its top bit.
  function automatic logic [PRICE_BITS-1:0] rand_price();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PRICE_MAX;
      2:       return PRICE_MAX - PRICE_BITS'($urandom_range(0, 255));
      3:       return PRICE_BITS'($urandom_range(0, 1000));
      default: return PRICE_BITS'($urandom);
    endcase
  endfunction

  // The result side's ready. The first assignment falls at time zero, so the port is
  // never left undriven, and no stall is empty, so that ready is never
  // lowered and raised within one time step.
  initial begin
    forever begin
      if (idle_mode == IDLE_NONE || idle_mode == IDLE_BARS) begin
        avg_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        avg_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        avg_ch.ready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end
    end
  end

  // Every result beat is checked at the clock edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && avg_ch.valid && avg_ch.ready)
      sb.check_result(avg_ch.window_index, avg_ch.average, avg_ch.last);
  end

  // The watchdog ends the run once no beat has moved on any channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((bar_ch.valid && bar_ch.ready) || (avg_ch.valid && avg_ch.ready) ||
          (reg_ch.valid && reg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one bar and waits for its beat. Valid is only lowered when a gap is wanted,
  // so back-to-back bars keep valid high without a dip in the same time step.
  task automatic send_bar(logic [PRICE_BITS-1:0] high_p, logic [PRICE_BITS-1:0] low_p);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      bar_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bar_ch.valid      <= 1'b1;
    bar_ch.high_price <= high_p;
    bar_ch.low_price  <= low_p;
    do @(posedge clk); while (!(bar_ch.valid && bar_ch.ready));
    sb.note_bar(high_p, low_p);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      reg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= data;
    do @(posedge clk); while (!(reg_ch.valid && reg_ch.ready));
    sb.apply_reg(idx, data);
  endtask

  task automatic release_regs();
    reg_ch.valid <= 1'b0;
  endtask

  // Closes a group of bars: stop offering, wait for every expected result, then give the
  // block time to finish the inactive windows before any register is touched.
  task automatic drain_bars(int unsigned settle);
    bar_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_avgs.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Random bars, with the idle pattern drawn afresh every thirty bars so that some
  // stretches run with no idling at all.
  task automatic send_random_bars(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 30 == 0) idle_mode = idle_mode_t'($urandom_range(0, 3));
      send_bar(rand_price(), rand_price());
    end
  endtask

  // The count register takes only its low bits, so the upper bits of the beat are filled
  // at random to show that they are ignored.
  function automatic logic [CFG_DATA_W-1:0] count_data(logic [CNT_BITS-1:0] cnt);
    return {(CFG_DATA_W - CNT_BITS)'($urandom), cnt};
  endfunction

  initial begin
    rst_n             <= 1'b0;
    bar_ch.valid      <= 1'b0;
    bar_ch.high_price <= '0;
    bar_ch.low_price  <= '0;
    reg_ch.valid      <= 1'b0;
    reg_ch.index      <= REG_WINDOW_COUNT;
    reg_ch.data       <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The reset settings give one window of twenty bars, so these bars
    // sit in warm-up: both prices at zero, both at maximum (the sum needs its carry bit),
    // one at each extreme, and a high below the low.
    idle_mode = IDLE_BOTH;
    send_bar('0, '0);
    send_bar(PRICE_MAX, PRICE_MAX);
    send_bar(PRICE_MAX, '0);
    send_bar(PRICE_BITS'(3), PRICE_BITS'(10));
    send_bar(PRICE_MAX, PRICE_MAX);
    drain_bars(SETTLE_CYCLES);

    // A count of seven saturates at four windows. Writing the count does not restart the
    // warm-up, and the three idle windows have been summing all along.
    write_reg(REG_WINDOW_COUNT, count_data(CNT_BITS'(7)));
    release_regs();
    send_bar(PRICE_MAX, PRICE_MAX);
    send_bar(PRICE_BITS'(1), '0);
    send_bar('0, PRICE_BITS'(1));
    drain_bars(SETTLE_CYCLES);

    // A zero length counts as one bar, lengths beyond the ring stop at its depth, and a
    // count of zero counts as one window. The length writes restart the warm-up.
    write_reg(REG_LEN_BASE,                  CFG_DATA_W'(0));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(1), CFG_DATA_W'(2));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(2), CFG_DATA_W'(300));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(3), CFG_DATA_W'(511));
    write_reg(REG_WINDOW_COUNT, count_data(CNT_BITS'(0)));
    release_regs();
    send_bar(PRICE_MAX, PRICE_MAX);
    send_bar('0, '0);
    send_bar(PRICE_MAX, PRICE_BITS'(1));
    drain_bars(SETTLE_CYCLES);

    // Back to four windows, then beats to the indexes past the last length register,
    // which the block must ignore without restarting anything.
    write_reg(REG_WINDOW_COUNT, count_data(CNT_BITS'(4)));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(LEN_REGS),     CFG_DATA_W'(9'h1FF));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(LEN_REGS + 1), CFG_DATA_W'(9'h0AA));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(LEN_REGS + 2), CFG_DATA_W'(9'h155));
    release_regs();
    send_bar(PRICE_MAX, PRICE_MAX);
    send_bar(PRICE_MAX, PRICE_MAX);
    send_bar('0, '0);
    send_bar(PRICE_MAX, PRICE_BITS'(1));
    send_bar(PRICE_BITS'(123456), PRICE_BITS'(7));
    send_bar('0, PRICE_MAX);
    drain_bars(SETTLE_CYCLES);

    // Rewriting a length with the value it already holds still restarts the warm-up.
    write_reg(REG_LEN_BASE, CFG_DATA_W'(0));
    release_regs();
    send_bar(PRICE_BITS'(1000), PRICE_BITS'(2000));
    send_bar(PRICE_MAX, '0);
    send_bar(PRICE_BITS'(5), PRICE_BITS'(5));
    drain_bars(SETTLE_CYCLES);

    // Random part. The first two groups share one warm-up of 270 bars, long enough for
    // the full-depth window to fill, saturate the bar count and wrap the ring; the count
    // change between them must not restart it.
    write_reg(REG_WINDOW_COUNT, count_data(CNT_BITS'(4)));
    write_reg(REG_LEN_BASE,                  CFG_DATA_W'(1));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(1), CFG_DATA_W'(HISTORY_DEPTH));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(2), CFG_DATA_W'($urandom_range(2, 255)));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(3), CFG_DATA_W'($urandom_range(2, 40)));
    release_regs();
    send_random_bars(150);
    drain_bars(SETTLE_CYCLES);

    write_reg(REG_WINDOW_COUNT, count_data(CNT_BITS'(2)));
    release_regs();
    send_random_bars(120);
    drain_bars(SETTLE_CYCLES);

    // Raw register values anywhere in their range, out-of-range ones included.
    write_reg(REG_LEN_BASE,                  CFG_DATA_W'($urandom_range(0, 511)));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(1), CFG_DATA_W'($urandom_range(0, 511)));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(2), CFG_DATA_W'($urandom_range(0, 511)));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(3), CFG_DATA_W'($urandom_range(0, 511)));
    write_reg(REG_WINDOW_COUNT, count_data(CNT_BITS'($urandom_range(0, 7))));
    release_regs();
    send_random_bars(50);
    drain_bars(SETTLE_CYCLES);

    // Short windows, so that every window slides many times within the group.
    write_reg(REG_LEN_BASE,                  CFG_DATA_W'($urandom_range(1, 16)));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(1), CFG_DATA_W'($urandom_range(1, 16)));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(2), CFG_DATA_W'($urandom_range(1, 16)));
    write_reg(REG_LEN_BASE + CFG_IDX_W'(3), CFG_DATA_W'($urandom_range(1, 16)));
    write_reg(REG_WINDOW_COUNT, count_data(CNT_BITS'(4)));
    release_regs();
    send_random_bars(50);

    // Wait for the last results, then watch a while longer for any stray beat.
    drain_bars(SETTLE_CYCLES);
    if (sb.expected_avgs.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_avgs.size()));
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mma_pkg.sv
rtl/core/mma_ifs.sv
rtl/core/mma_ring_ram.sv
rtl/core/mma_div.sv
rtl/core/mma_cfg_regs.sv
rtl/core/midpoint_moving_average_top.sv
tb/tb_top.sv
